[rtl/mrfp_pkg.sv]
// Package for the meter reply frame parser: status codes, frame constants and
// the decoded-frame record that passes from the frame tracker to the value stage.
// No dependencies.
`default_nettype none

package mrfp_pkg;

  // Result status codes, as carried on the master-side tuser.
  typedef enum logic [2:0] {
    ST_VOLT    = 3'd0,
    ST_CURR    = 3'd1,
    ST_ENERGY  = 3'd2,
    ST_EXCEPT  = 3'd3,
    ST_CSBAD   = 3'd4,
    ST_IGNORED = 3'd5,
    ST_SHORT   = 3'd6
  } status_e;

  // Field widths.
  localparam int unsigned ThreshW = 18;
  localparam int unsigned ValueW  = 28;
  localparam int unsigned OutDataW = 40;

  // Frame byte codes.
  localparam logic [7:0] START_BYTE  = 8'h68;
  localparam logic [7:0] CTRL_NORMAL = 8'h91;
  localparam logic [7:0] CTRL_EXCEPT = 8'hD1;
  localparam logic [7:0] DATA_BIAS   = 8'h33;
  localparam logic [7:0] LEN_VOLT    = 8'h06;
  localparam logic [7:0] LEN_CURR    = 8'h07;
  localparam logic [7:0] LEN_ENERGY  = 8'h08;

  localparam logic [ThreshW-1:0] THRESH_RESET = 18'd100;

  // One finished frame: status, data bytes with the bias removed, error byte.
  typedef struct packed {
    status_e         status;
    logic [3:0][7:0] data;
    logic [7:0]      err;
  } dec_t;

endpackage

`default_nettype wire

[rtl/mrfp_value.sv]
// Value stage of the meter reply frame parser: weights the BCD nibbles of a
// decoded frame and compares a current reading with the threshold. Uses mrfp_pkg.
`default_nettype none

module mrfp_value (
  input  mrfp_pkg::dec_t                 dec_i,
  input  logic [mrfp_pkg::ThreshW-1:0]   thr_i,
  output logic [mrfp_pkg::ValueW-1:0]    value_o,
  output logic                           above_o
);
  import mrfp_pkg::*;

  logic [3:0][ValueW-1:0] hi_w;
  logic [3:0][ValueW-1:0] lo_w;

  // Nibbles widened to the value width.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hi_w[k] = ValueW'(dec_i.data[k][7:4]);
      lo_w[k] = ValueW'(dec_i.data[k][3:0]);
    end
  end

  // Decimal weighting per reading kind; a nibble above nine keeps its own value.
  always_comb begin
    case (dec_i.status)
      ST_VOLT: begin
        value_o = hi_w[0] * 28'd100 + lo_w[0] * 28'd10
                + hi_w[1] * 28'd10000 + lo_w[1] * 28'd1000;
      end
      ST_CURR: begin
        value_o = hi_w[0]
                + hi_w[1] * 28'd100 + lo_w[1] * 28'd10
                + hi_w[2] * 28'd10000 + lo_w[2] * 28'd1000;
      end
      ST_ENERGY: begin
        value_o = lo_w[0] + hi_w[0] * 28'd10
                + lo_w[1] * 28'd100 + hi_w[1] * 28'd1000
                + lo_w[2] * 28'd10000 + hi_w[2] * 28'd100000
                + lo_w[3] * 28'd1000000 + hi_w[3] * 28'd10000000;
      end
      default: begin
        value_o = '0;
      end
    endcase
  end

  // Threshold flag, only for current readings.
  assign above_o = (dec_i.status == ST_CURR) && (value_o > ValueW'(thr_i));

endmodule

`default_nettype wire

[rtl/meter_reply_frame_parser.sv]
// Top level of the meter reply frame parser: byte tracking, frame decode and
// output register. Depends on mrfp_pkg and mrfp_value.
//
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      tdata[7:0] rx_byte, tlast frame_end
// m_axis    out  tvalid/tready      tdata value/error_word/current_above, tuser status
// cfg       in   cfg_wen_i          cfg_wdata_i current_threshold
//
// One byte is taken per cycle while the slave side is ready. A byte marked tlast
// is decoded into a frame register in the cycle it is taken, and its value is
// formed into the output register once that register is free.
// Reset clears all frame state and restores the threshold to 100. The slave side
// stalls only while a decoded frame waits behind an unaccepted result.
`default_nettype none

module meter_reply_frame_parser #(
  parameter int unsigned MAX_FRAME = 255
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Threshold register write.
  input  logic                         cfg_wen_i,
  input  logic [mrfp_pkg::ThreshW-1:0] cfg_wdata_i,
  // Byte stream in.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                         s_axis_tlast_i,   // frame_end
  // Result stream out.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [27:0] value, [35:28] error_word, [36] current_above, [39:37] zero
  output logic [mrfp_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [2:0]                   m_axis_tuser_o    // [2:0] status
);
  import mrfp_pkg::*;

  localparam int unsigned OfsW = $clog2(MAX_FRAME + 1);
  localparam logic [OfsW-1:0] OfsMax  = OfsW'(MAX_FRAME);
  localparam logic [OfsW-1:0] OfsCtrl = OfsW'(8);
  localparam logic [OfsW-1:0] OfsLen  = OfsW'(9);
  localparam logic [OfsW-1:0] OfsData = OfsW'(14);
  localparam logic [OfsW-1:0] OfsDataEnd = OfsW'(18);
  localparam logic [OfsW-1:0] MinHdr  = OfsW'(11);
  localparam logic [OfsW-1:0] MinVolt = OfsW'(17);
  localparam logic [OfsW-1:0] MinCurr = OfsW'(18);
  localparam logic [OfsW-1:0] MinEnergy = OfsW'(19);

  // Handshake signals.
  logic in_acc, in_acc_end, out_load;

  // Frame tracking state.
  logic            start_seen_q, start_seen_d;
  logic [OfsW-1:0] ofs_q, ofs_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      prev_q, prev_d;
  logic [7:0]      pprev_q, pprev_d;
  logic            prev_cnt_q, prev_cnt_d;
  logic            pprev_cnt_q, pprev_cnt_d;
  logic [7:0]      ctrl_q, ctrl_d;
  logic [7:0]      len_q, len_d;
  logic [3:0][7:0] pay_q, pay_d;

  // Decode stage and output register.
  logic                dec_valid_q, dec_valid_d;
  dec_t                dec_q, dec_d;
  logic [ThreshW-1:0]  thr_q;
  logic                out_valid_q, out_valid_d;
  logic [ValueW-1:0]   value_c;
  logic                above_c;
  logic [ValueW-1:0]   out_value_q;
  logic [7:0]          out_err_q;
  logic                out_above_q;
  status_e             out_status_q;

  // Per-byte working values.
  logic            start_now;
  logic [OfsW-1:0] ofs_now;
  logic [7:0]      sum_end;
  logic [OfsW-1:0] ofs_rel;

  assign out_load        = dec_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !dec_valid_q || !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_acc_end      = in_acc && s_axis_tlast_i;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_wen_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Offset of the current byte from the start byte, saturating.
  always_comb begin
    start_now = start_seen_q || (s_axis_tdata_i == START_BYTE);
    if (!start_seen_q) begin
      ofs_now = '0;
    end else if (ofs_q < OfsMax) begin
      ofs_now = ofs_q + OfsW'(1);
    end else begin
      ofs_now = ofs_q;
    end
    ofs_rel = ofs_now - OfsData;
    sum_end = sum_q + (pprev_cnt_q ? pprev_q : 8'd0);
  end

  // Frame tracking next state; everything is cleared after the last byte.
  always_comb begin
    start_seen_d = start_seen_q;
    ofs_d        = ofs_q;
    sum_d        = sum_q;
    prev_d       = prev_q;
    pprev_d      = pprev_q;
    prev_cnt_d   = prev_cnt_q;
    pprev_cnt_d  = pprev_cnt_q;
    ctrl_d       = ctrl_q;
    len_d        = len_q;
    pay_d        = pay_q;
    if (in_acc_end) begin
      start_seen_d = 1'b0;
      ofs_d        = '0;
      sum_d        = '0;
      prev_d       = '0;
      pprev_d      = '0;
      prev_cnt_d   = 1'b0;
      pprev_cnt_d  = 1'b0;
      ctrl_d       = '0;
      len_d        = '0;
      pay_d        = '0;
    end else if (in_acc) begin
      start_seen_d = start_now;
      ofs_d        = ofs_now;
      if (start_now) begin
        if (ofs_now == OfsCtrl) begin
          ctrl_d = s_axis_tdata_i;
        end else if (ofs_now == OfsLen) begin
          len_d = s_axis_tdata_i;
        end else if (ofs_now >= OfsData && ofs_now < OfsDataEnd) begin
          pay_d[ofs_rel[1:0]] = s_axis_tdata_i;
        end
      end
      sum_d       = sum_end;
      pprev_d     = prev_q;
      pprev_cnt_d = prev_cnt_q;
      prev_d      = s_axis_tdata_i;
      prev_cnt_d  = start_now;
    end
  end

  // Frame checks on the last byte, in order of precedence.
  always_comb begin
    dec_d.err = '0;
    for (int k = 0; k < 4; k++) begin
      dec_d.data[k] = pay_q[k] - DATA_BIAS;
    end
    if (!start_now) begin
      dec_d.status = ST_SHORT;
    end else if (ofs_now >= OfsMax) begin
      dec_d.status = ST_IGNORED;
    end else if (ofs_now < MinHdr) begin
      dec_d.status = ST_SHORT;
    end else if (sum_end != prev_q) begin
      dec_d.status = ST_CSBAD;
    end else if (ctrl_q == CTRL_NORMAL) begin
      if (len_q == LEN_VOLT) begin
        dec_d.status = (ofs_now < MinVolt) ? ST_SHORT : ST_VOLT;
      end else if (len_q == LEN_CURR) begin
        dec_d.status = (ofs_now < MinCurr) ? ST_SHORT : ST_CURR;
      end else if (len_q == LEN_ENERGY) begin
        dec_d.status = (ofs_now < MinEnergy) ? ST_SHORT : ST_ENERGY;
      end else begin
        dec_d.status = ST_IGNORED;
      end
    end else if (ctrl_q == CTRL_EXCEPT) begin
      dec_d.status = ST_EXCEPT;
      dec_d.err    = pprev_q;
    end else begin
      dec_d.status = ST_IGNORED;
    end
  end

  // Decode stage holds a finished frame until the output register is free.
  always_comb begin
    dec_valid_d = dec_valid_q;
    if (out_load) begin
      dec_valid_d = 1'b0;
    end
    if (in_acc_end) begin
      dec_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  mrfp_value u_value (
    .dec_i   (dec_q),
    .thr_i   (thr_q),
    .value_o (value_c),
    .above_o (above_c)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_seen_q <= 1'b0;
      ofs_q        <= '0;
      sum_q        <= '0;
      prev_q       <= '0;
      pprev_q      <= '0;
      prev_cnt_q   <= 1'b0;
      pprev_cnt_q  <= 1'b0;
      ctrl_q       <= '0;
      len_q        <= '0;
      pay_q        <= '0;
      dec_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      start_seen_q <= start_seen_d;
      ofs_q        <= ofs_d;
      sum_q        <= sum_d;
      prev_q       <= prev_d;
      pprev_q      <= pprev_d;
      prev_cnt_q   <= prev_cnt_d;
      pprev_cnt_q  <= pprev_cnt_d;
      ctrl_q       <= ctrl_d;
      len_q        <= len_d;
      pay_q        <= pay_d;
      dec_valid_q  <= dec_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc_end) begin
      dec_q <= dec_d;
    end
    if (out_load) begin
      out_status_q <= dec_q.status;
      out_value_q  <= value_c;
      out_err_q    <= dec_q.err;
      out_above_q  <= above_c;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {3'b000, out_above_q, out_err_q, out_value_q};

  // A decoded frame is never dropped while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_valid_q && !out_load |=> dec_valid_q)
    else $error("decoded frame lost while output stalled");

  // A decoded frame only ever comes from a last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tlast_i && !dec_valid_q |=> !dec_valid_q)
    else $error("decoded frame without a last byte");

  // Frame state is cleared after every last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc_end |=> !start_seen_q && sum_q == 8'd0 && !prev_cnt_q && !pprev_cnt_q)
    else $error("frame state not cleared after last byte");

  // The threshold flag only accompanies a current reading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_above_q |-> out_status_q == ST_CURR)
    else $error("threshold flag on a non-current result");

  // Only readings carry a non-zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_value_q != '0 |->
      out_status_q == ST_VOLT || out_status_q == ST_CURR || out_status_q == ST_ENERGY)
    else $error("value set on a non-reading result");

endmodule

`default_nettype wire

[dv/mrfp_reply_checker.sv]
// Checker for the meter reply frame parser: watches the threshold write port and
// both streams, predicts each frame result and compares it field by field.
// Depends on mrfp_pkg for the status codes, frame constants and field widths.
module mrfp_reply_checker #(
  parameter int unsigned MAX_FRAME = 255
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_wen_i,
  input  logic [mrfp_pkg::ThreshW-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  input  logic [7:0]                   s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                         s_axis_tlast_i,   // frame_end
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  // [27:0] value, [35:28] error_word, [36] current_above, [39:37] zero
  input  logic [mrfp_pkg::OutDataW-1:0] m_axis_tdata_i,
  input  logic [2:0]                   m_axis_tuser_i,   // [2:0] status
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mrfp_pkg::*;

  localparam logic [7:0] OfsCtrl = 8'd8;
  localparam logic [7:0] OfsLen  = 8'd9;
  localparam logic [7:0] OfsData = 8'd14;

  typedef struct packed {
    status_e           status;
    logic [ValueW-1:0] value;
    logic [7:0]        err_word;
    logic              above;
  } reply_t;

  // Frame tracking state of the predictor.
  logic               in_frame;
  logic [7:0]         ofs;
  logic [7:0]         csum_acc;
  logic [7:0]         last_b;
  logic [7:0]         last2_b;
  logic               last_in;
  logic               last2_in;
  logic [7:0]         ctrl_q;
  logic [7:0]         len_q;
  logic [3:0][7:0]    pay_q;
  logic [ThreshW-1:0] thresh_q;

  reply_t      expected_replies[$];
  int unsigned fails;
  int unsigned checked;

  // Every frame starts from a clean slate; the threshold is kept.
  function automatic void clear_frame();
    in_frame = 1'b0;
    ofs      = '0;
    csum_acc = '0;
    last_b   = '0;
    last2_b  = '0;
    last_in  = 1'b0;
    last2_in = 1'b0;
    ctrl_q   = '0;
    len_q    = '0;
    pay_q    = '0;
  endfunction

  // Advances the frame state by one byte and, on the last byte of a frame,
  // queues the decoded result.
  task automatic parse_rx_byte(input logic [7:0] b, input logic eof);
    logic            counted_now;
    logic [7:0]      csum;
    logic [7:0]      unb;
    logic [3:0][3:0] hi;
    logic [3:0][3:0] lo;
    int unsigned     need;
    int unsigned     val;
    logic [7:0]      err;
    logic            above;
    status_e         st;
    reply_t          reply;
    if (!in_frame) begin
      if (b == START_BYTE) begin
        in_frame = 1'b1;
        ofs      = '0;
      end
    end else if (ofs < MAX_FRAME) begin
      ofs = ofs + 8'd1;
    end
    counted_now = in_frame;
    if (counted_now) begin
      if (ofs == OfsCtrl) begin
        ctrl_q = b;
      end else if (ofs == OfsLen) begin
        len_q = b;
      end else if (ofs >= OfsData && ofs < OfsData + 8'd4) begin
        pay_q[2'(ofs - OfsData)] = b;
      end
    end

    if (!eof) begin
      // The checksum lags two bytes behind, as the last two are not summed.
      if (last2_in) csum_acc = csum_acc + last2_b;
      last2_b  = last_b;
      last2_in = last_in;
      last_b   = b;
      last_in  = counted_now;
    end else begin
      csum = csum_acc;
      if (last2_in) csum = csum + last2_b;
      val   = 0;
      err   = '0;
      above = 1'b0;
      need  = 0;
      for (int k = 0; k < 4; k++) begin
        unb   = pay_q[k] - DATA_BIAS;
        hi[k] = unb[7:4];
        lo[k] = unb[3:0];
      end

      if (!in_frame) begin
        st = ST_SHORT;
      end else if (ofs >= MAX_FRAME) begin
        st = ST_IGNORED;
      end else if (ofs < 8'd11) begin
        st = ST_SHORT;
      end else if (csum != last_b) begin
        st = ST_CSBAD;
      end else if (ctrl_q == CTRL_NORMAL) begin
        case (len_q)
          LEN_VOLT: begin
            need = 2;
            st   = ST_VOLT;
          end
          LEN_CURR: begin
            need = 3;
            st   = ST_CURR;
          end
          LEN_ENERGY: begin
            need = 4;
            st   = ST_ENERGY;
          end
          default: begin
            need = 0;
            st   = ST_IGNORED;
          end
        endcase
        // Nibbles above nine still count with their own weight.
        if (need != 0 && ofs < 15 + need) begin
          st = ST_SHORT;
        end else if (st == ST_VOLT) begin
          val = 32'(hi[0]) * 100 + 32'(lo[0]) * 10
              + 32'(hi[1]) * 10000 + 32'(lo[1]) * 1000;
        end else if (st == ST_CURR) begin
          val = 32'(hi[0])
              + 32'(hi[1]) * 100 + 32'(lo[1]) * 10
              + 32'(hi[2]) * 10000 + 32'(lo[2]) * 1000;
          above = (val > 32'(thresh_q));
        end else if (st == ST_ENERGY) begin
          val = 32'(lo[0]) + 32'(hi[0]) * 10
              + 32'(lo[1]) * 100 + 32'(hi[1]) * 1000
              + 32'(lo[2]) * 10000 + 32'(hi[2]) * 100000
              + 32'(lo[3]) * 1000000 + 32'(hi[3]) * 10000000;
        end
      end else if (ctrl_q == CTRL_EXCEPT) begin
        st  = ST_EXCEPT;
        err = last2_b;
      end else begin
        st = ST_IGNORED;
      end

      reply.status   = st;
      reply.value    = val[ValueW-1:0];
      reply.err_word = err;
      reply.above    = above;
      expected_replies.push_back(reply);
      clear_frame();
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  // Compares one result transfer with the oldest outstanding prediction.
  task automatic check_reply();
    reply_t want;
    if (expected_replies.size() == 0) begin
      $error("result with nothing expected: status %0d, tdata 0x%0h",
             m_axis_tuser_i, m_axis_tdata_i);
      fails++;
    end else begin
      want = expected_replies.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(m_axis_tuser_i));
      compare_field("value", 32'(want.value), 32'(m_axis_tdata_i[27:0]));
      compare_field("error_word", 32'(want.err_word), 32'(m_axis_tdata_i[35:28]));
      compare_field("current_above", 32'(want.above), 32'(m_axis_tdata_i[36]));
      compare_field("tdata padding", 32'd0, 32'(m_axis_tdata_i[39:37]));
    end
  endtask

  // Bytes are predicted before results are compared within the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      thresh_q = THRESH_RESET;
      expected_replies.delete();
      fails        = 0;
      checked      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_wen_i) thresh_q = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_i) parse_rx_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_reply();
      fail_count_o <= fails;
      pending_o    <= expected_replies.size();
      checked_o    <= checked;
    end
  end

endmodule

[dv/tb.sv]
// Top of the meter reply frame parser testbench: clock, reset, frame stimulus,
// threshold settings and the verdict. Depends on mrfp_pkg, the parser and
// mrfp_reply_checker, which does all prediction and comparison.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrfp_pkg::*;

  localparam int unsigned MaxFrame     = 255;
  localparam int unsigned IdlePct      = 35;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned NumPhases    = 4;
  localparam logic [ThreshW-1:0] ThreshMax = 18'd166665;
  localparam logic [7:0] END_BYTE = 8'h16;

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                cfg_wen   = 1'b0;
  logic [ThreshW-1:0]  cfg_wdata = '0;
  logic                s_valid   = 1'b0;
  logic                s_ready;
  logic [7:0]          s_data    = '0;
  logic                s_last    = 1'b0;
  logic                m_valid;
  logic                m_ready   = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic [2:0]          m_user;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  logic        gaps_on = 1'b1;
  int unsigned quiet   = 0;
  int unsigned bytes_sent  = 0;
  int unsigned frames_sent = 0;
  logic [7:0]  frame_q[$];

  meter_reply_frame_parser #(
    .MAX_FRAME(MaxFrame)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wen_i      (cfg_wen),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  mrfp_reply_checker #(
    .MAX_FRAME(MaxFrame)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wen_i      (cfg_wen),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_i (m_data),
    .m_axis_tuser_i (m_user),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The result side stalls at random while gaps are enabled.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= gaps_on ? ($urandom_range(99) >= IdlePct) : 1'b1;
    end
  end

  // Watchdog: ends the run if no transfer happens on either stream for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= StallLimit) begin
      $display("meter_reply_frame_parser test failed");
      $finish;
    end
  end

  // Wake-up bytes ahead of the frame; never the start byte itself.
  task automatic add_preamble(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = ($urandom_range(1) == 0) ? 8'hFE : 8'($urandom);
      if (b == START_BYTE) b = 8'hFE;
      frame_q.push_back(b);
    end
  endtask

  // Start byte, address, second start byte, control code and data length.
  task automatic add_header(input logic [7:0] ctrl, input logic [7:0] len);
    frame_q.push_back(START_BYTE);
    repeat (6) frame_q.push_back(8'($urandom));
    frame_q.push_back(START_BYTE);
    frame_q.push_back(ctrl);
    frame_q.push_back(len);
  endtask

  // Biased data bytes: mostly two decimal digits, now and then any byte.
  task automatic add_data(input int unsigned n);
    logic [7:0] raw;
    repeat (n) begin
      if ($urandom_range(9) == 0) raw = 8'($urandom);
      else raw = {4'($urandom_range(9)), 4'($urandom_range(9))};
      frame_q.push_back(raw + DATA_BIAS);
    end
  endtask

  // Checksum over everything from the first start byte, then the end byte.
  task automatic close_frame(input logic bad_sum);
    logic [7:0] sum;
    logic       counting;
    sum      = '0;
    counting = 1'b0;
    foreach (frame_q[i]) begin
      if (frame_q[i] == START_BYTE) counting = 1'b1;
      if (counting) sum = sum + frame_q[i];
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
    frame_q.push_back(sum);
    frame_q.push_back(END_BYTE);
  endtask

  // One byte transfer, with random idle cycles ahead of it while gaps are on.
  task automatic push_byte(input logic [7:0] b, input logic eof);
    if (gaps_on) begin
      while ($urandom_range(99) < IdlePct) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= eof;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
    frames_sent++;
  endtask

  // Holds the sender until every outstanding result has been taken.
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThreshW-1:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_wen   <= 1'b0;
  endtask

  initial begin
    int unsigned        phase_start;
    int unsigned        phase_frames;
    int unsigned        pick;
    int unsigned        cut;
    logic [7:0]         len;
    logic [7:0]         ctrl;
    logic [ThreshW-1:0] thr;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset threshold.
    // Single-byte frames: a lone start byte, then a byte with no start.
    frame_q.push_back(START_BYTE);
    send_frame();
    frame_q.push_back(8'hFF);
    send_frame();
    // No start byte anywhere in the frame.
    repeat (5) frame_q.push_back(8'hFE);
    send_frame();
    // Voltage with random digits, then with raw zero bytes that wrap on unbiasing.
    add_preamble(4);
    add_header(CTRL_NORMAL, LEN_VOLT);
    add_data(LEN_VOLT);
    close_frame(1'b0);
    send_frame();
    add_header(CTRL_NORMAL, LEN_VOLT);
    repeat (6) frame_q.push_back(8'h00);
    close_frame(1'b0);
    send_frame();
    // Current exactly at the threshold of 100, then one above it.
    add_header(CTRL_NORMAL, LEN_CURR);
    add_data(4);
    frame_q.push_back(8'h33);
    frame_q.push_back(8'h43);
    frame_q.push_back(8'h33);
    close_frame(1'b0);
    send_frame();
    add_header(CTRL_NORMAL, LEN_CURR);
    add_data(4);
    frame_q.push_back(8'h43);
    frame_q.push_back(8'h43);
    frame_q.push_back(8'h33);
    close_frame(1'b0);
    send_frame();
    // Energy with all digits at nine, then with every nibble above nine.
    add_header(CTRL_NORMAL, LEN_ENERGY);
    add_data(4);
    repeat (4) frame_q.push_back(8'hCC);
    close_frame(1'b0);
    send_frame();
    add_header(CTRL_NORMAL, LEN_ENERGY);
    add_data(4);
    repeat (4) frame_q.push_back(8'hFF);
    close_frame(1'b0);
    send_frame();
    // Meter exceptions, the shortest one with no data byte at all.
    add_header(CTRL_EXCEPT, 8'h01);
    frame_q.push_back(8'hFF);
    close_frame(1'b0);
    send_frame();
    add_header(CTRL_EXCEPT, 8'h01);
    frame_q.push_back(8'h00);
    close_frame(1'b0);
    send_frame();
    add_header(CTRL_EXCEPT, 8'h00);
    close_frame(1'b0);
    send_frame();
    // Bad checksum.
    add_header(CTRL_NORMAL, LEN_CURR);
    add_data(LEN_CURR);
    close_frame(1'b1);
    send_frame();
    // Normal replies with unsupported lengths, and an unknown control code.
    add_header(CTRL_NORMAL, 8'h05);
    add_data(5);
    close_frame(1'b0);
    send_frame();
    add_header(CTRL_NORMAL, 8'hFF);
    add_data(4);
    close_frame(1'b0);
    send_frame();
    add_header(8'h11, LEN_VOLT);
    add_data(LEN_VOLT);
    close_frame(1'b0);
    send_frame();
    // Frame too short to hold a checksum and an end byte after control and length.
    add_header(CTRL_NORMAL, LEN_VOLT);
    frame_q.push_back(8'h33);
    send_frame();
    // Energy reply with a valid checksum but one data byte missing.
    add_header(CTRL_NORMAL, LEN_ENERGY);
    add_data(7);
    close_frame(1'b0);
    send_frame();
    // Frame that just reaches the saturated offset, sent as one unbroken burst.
    gaps_on = 1'b0;
    frame_q.push_back(START_BYTE);
    repeat (MaxFrame) frame_q.push_back(8'($urandom));
    send_frame();
    gaps_on = 1'b1;

    // Random frames, one threshold setting per phase; one phase runs without gaps.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      case (ph)
        0:       thr = '0;
        1:       thr = ThreshMax;
        default: thr = ThreshW'($urandom_range(ThreshMax));
      endcase
      write_threshold(thr);
      gaps_on      = (ph != 1);
      phase_start  = bytes_sent;
      phase_frames = 0;
      while (bytes_sent - phase_start < 32 || phase_frames < 2) begin
        pick = $urandom_range(99);
        add_preamble($urandom_range(4));
        if (pick < 55) begin
          len = 8'(LEN_VOLT + $urandom_range(2));
          add_header(CTRL_NORMAL, len);
          add_data(len);
          close_frame(1'b0);
        end else if (pick < 65) begin
          add_header(CTRL_EXCEPT, 8'h01);
          frame_q.push_back(8'($urandom));
          close_frame(1'b0);
        end else if (pick < 73) begin
          len = 8'(LEN_VOLT + $urandom_range(2));
          add_header(CTRL_NORMAL, len);
          add_data(len);
          close_frame(1'b1);
        end else if (pick < 80) begin
          len = 8'($urandom_range(15));
          add_header(CTRL_NORMAL, len);
          add_data(len);
          close_frame(1'b0);
        end else if (pick < 85) begin
          ctrl = 8'($urandom);
          len  = 8'($urandom_range(8));
          add_header(ctrl, len);
          add_data(len);
          close_frame(1'b0);
        end else if (pick < 92) begin
          // A well-formed reply cut short at a random byte.
          len = 8'(LEN_VOLT + $urandom_range(2));
          add_header(CTRL_NORMAL, len);
          add_data(len);
          close_frame(1'b0);
          cut = $urandom_range(frame_q.size() - 1, 1);
          repeat (cut) void'(frame_q.pop_back());
        end else begin
          repeat ($urandom_range(24, 1)) frame_q.push_back(8'($urandom));
        end
        send_frame();
        phase_frames++;
      end
    end

    gaps_on = 1'b1;
    drain_results();
    $display("Sent %0d frames (%0d bytes) across %0d threshold settings.",
             frames_sent, bytes_sent, NumPhases + 1);
    $display("Checked %0d results covering every status code and frame defect.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("meter_reply_frame_parser test passed");
    end else begin
      $display("meter_reply_frame_parser test failed");
    end
    $finish;
  end

endmodule

[meter_reply_frame_parser.f]
rtl/mrfp_pkg.sv
rtl/mrfp_value.sv
rtl/meter_reply_frame_parser.sv
dv/mrfp_reply_checker.sv
dv/tb.sv
